[hdl/cfsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsc_pkg
// Types, codes and reset values shared by the clock field setting controller.
// ----------------------------------------------------------------------------
package cfsc_pkg;

    localparam int LEVEL_W = 10;
    localparam int CFG_IDX_W = 3;

    // decoded key codes
    typedef enum logic [2:0] {
        KEY_RIGHT  = 3'd0,
        KEY_UP     = 3'd1,
        KEY_DOWN   = 3'd2,
        KEY_LEFT   = 3'd3,
        KEY_SELECT = 3'd4,
        KEY_NONE   = 3'd5
    } key_t;

    // operation codes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_BLINK = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // field codes
    localparam logic [2:0] FIELD_HOURS   = 3'd0;
    localparam logic [2:0] FIELD_MINUTES = 3'd1;
    localparam logic [2:0] FIELD_SECONDS = 3'd2;
    localparam logic [2:0] FIELD_DAY     = 3'd3;
    localparam logic [2:0] FIELD_MONTH   = 3'd4;
    localparam logic [2:0] FIELD_YEAR    = 3'd5;
    localparam logic [2:0] NO_FIELD      = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_LIMIT = 3'd4;

    localparam logic [LEVEL_W-1:0] RIGHT_LIMIT_RST  = 10'd50;
    localparam logic [LEVEL_W-1:0] UP_LIMIT_RST     = 10'd195;
    localparam logic [LEVEL_W-1:0] DOWN_LIMIT_RST   = 10'd380;
    localparam logic [LEVEL_W-1:0] LEFT_LIMIT_RST   = 10'd555;
    localparam logic [LEVEL_W-1:0] SELECT_LIMIT_RST = 10'd790;

    typedef struct packed {
        logic [LEVEL_W-1:0] right_limit;
        logic [LEVEL_W-1:0] up_limit;
        logic [LEVEL_W-1:0] down_limit;
        logic [LEVEL_W-1:0] left_limit;
        logic [LEVEL_W-1:0] select_limit;
    } limits_t;

    // held date and time
    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } clk_time_t;

    localparam clk_time_t TIME_RST = '{
        hours: 5'd12, minutes: 6'd0, seconds: 6'd0,
        day: 5'd1, month: 4'd1, year: 14'd21
    };

    localparam logic [13:0] YEAR_MAX = 14'd9999;

endpackage

[hdl/clock_field_setting_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_field_setting_controller_unit
// Edits a held date and time from a resistor-ladder keypad.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one item per transfer: a key
//   sample, a blink tick or a load of clock readings, chosen by operation.
//   every item yields exactly one result on the output channel
//   (out_valid/out_ready): the held date and time after the item, the edit
//   status, the blanked field and a commit flag on the item leaving edit mode.
//   the cfg_write/cfg_index/cfg_data port sets the five key thresholds; write
//   it only while no item is in flight.
// timing:
//   an item is held in the input register, is worked in a single
//   combinational pass (threshold compare chain, then the field wrap adders)
//   and lands in the result register; one item per cycle unless stalled.
// reset:
//   rst_n clears both pipeline valid bits, loads the default thresholds and
//   sets the time to 12:00:00 on day 1, month 1, year 21, out of edit mode.
// stall:
//   when out_ready is low the result holds; the input register still takes
//   one more item, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module clock_field_setting_controller_unit (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_write,
    input  logic [cfsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfsc_pkg::LEVEL_W-1:0]   cfg_data,

    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   operation,
    input  logic [9:0]   key_level,
    input  logic [4:0]   load_hours,
    input  logic [5:0]   load_minutes,
    input  logic [5:0]   load_seconds,
    input  logic [4:0]   load_day,
    input  logic [3:0]   load_month,
    input  logic [13:0]  load_year,

    output logic         out_valid,
    input  logic         out_ready,
    output logic [4:0]   hours_out,
    output logic [5:0]   minutes_out,
    output logic [5:0]   seconds_out,
    output logic [4:0]   day_out,
    output logic [3:0]   month_out,
    output logic [13:0]  year_out,
    output logic         editing_active,
    output logic [2:0]   chosen_field,
    output logic [2:0]   blanked_field,
    output logic         commit
);
    import cfsc_pkg::*;

    // configuration thresholds
    limits_t    limits_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [9:0] level_reg;
    clk_time_t  load_reg;

    // controller state
    key_t       prev_key_reg, prev_key_next;
    logic       in_setup_reg, in_setup_next;
    logic [2:0] edit_field_reg, edit_field_next;
    logic       blink_reg, blink_next;
    logic [2:0] hidden_reg, hidden_next;
    clk_time_t  time_reg, time_next;
    logic       commit_next;

    // result register
    logic       out_valid_reg;
    clk_time_t  res_time_reg;
    logic       res_setup_reg;
    logic [2:0] res_field_reg;
    logic [2:0] res_hidden_reg;
    logic       res_commit_reg;

    logic       advance;
    key_t       key;
    logic       fresh;
    clk_time_t  stepped;

    // work the held item when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.right_limit  <= RIGHT_LIMIT_RST;
            limits_reg.up_limit     <= UP_LIMIT_RST;
            limits_reg.down_limit   <= DOWN_LIMIT_RST;
            limits_reg.left_limit   <= LEFT_LIMIT_RST;
            limits_reg.select_limit <= SELECT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RIGHT_LIMIT:  limits_reg.right_limit  <= cfg_data;
                REG_UP_LIMIT:     limits_reg.up_limit     <= cfg_data;
                REG_DOWN_LIMIT:   limits_reg.down_limit   <= cfg_data;
                REG_LEFT_LIMIT:   limits_reg.left_limit   <= cfg_data;
                REG_SELECT_LIMIT: limits_reg.select_limit <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register: valid bit under reset, payload loaded on transfer, no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg          <= operation;
            level_reg       <= key_level;
            load_reg.hours   <= load_hours;
            load_reg.minutes <= load_minutes;
            load_reg.seconds <= load_seconds;
            load_reg.day     <= load_day;
            load_reg.month   <= load_month;
            load_reg.year    <= load_year;
        end
    end

    cfsc_key_decode u_key_decode (
        .limits (limits_reg),
        .level  (level_reg),
        .key    (key)
    );

    // up steps the field, anything else reaching here is a down step
    cfsc_field_step u_field_step (
        .cur     (time_reg),
        .field   (edit_field_reg),
        .up      (key == KEY_UP),
        .stepped (stepped)
    );

    assign fresh = (key != prev_key_reg);

    always_comb
    begin
        prev_key_next   = prev_key_reg;
        in_setup_next   = in_setup_reg;
        edit_field_next = edit_field_reg;
        blink_next      = blink_reg;
        hidden_next     = hidden_reg;
        time_next       = time_reg;
        commit_next     = 1'b0;

        unique case (op_reg)
            OP_KEY:
            begin
                prev_key_next = key;
                if (!in_setup_reg)
                begin
                    // fresh select enters edit mode on hours
                    if (key == KEY_SELECT && fresh)
                    begin
                        in_setup_next   = 1'b1;
                        edit_field_next = FIELD_HOURS;
                        hidden_next     = blink_reg ? FIELD_HOURS : NO_FIELD;
                    end
                end
                else if (fresh)
                begin
                    unique case (key)
                        KEY_SELECT:
                        begin
                            in_setup_next = 1'b0;
                            hidden_next   = NO_FIELD;
                            commit_next   = 1'b1;
                        end
                        KEY_UP, KEY_DOWN:
                            time_next = stepped;
                        KEY_LEFT:
                            edit_field_next = (edit_field_reg == FIELD_HOURS) ?
                                              FIELD_YEAR : edit_field_reg - 3'd1;
                        KEY_RIGHT:
                            edit_field_next = (edit_field_reg == FIELD_YEAR) ?
                                              FIELD_HOURS : edit_field_reg + 3'd1;
                        default: ;  // no key
                    endcase
                end
            end
            OP_BLINK:
            begin
                if (in_setup_reg)
                begin
                    blink_next  = !blink_reg;
                    hidden_next = !blink_reg ? edit_field_reg : NO_FIELD;
                end
            end
            OP_LOAD:
            begin
                if (!in_setup_reg)
                    time_next = load_reg;
            end
            default: ;  // unused operation leaves state alone
        endcase
    end

    // state moves only when an item is worked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg   <= KEY_NONE;
            in_setup_reg   <= 1'b0;
            edit_field_reg <= FIELD_HOURS;
            blink_reg      <= 1'b0;
            hidden_reg     <= NO_FIELD;
            time_reg       <= TIME_RST;
        end
        else if (advance)
        begin
            prev_key_reg   <= prev_key_next;
            in_setup_reg   <= in_setup_next;
            edit_field_reg <= edit_field_next;
            blink_reg      <= blink_next;
            hidden_reg     <= hidden_next;
            time_reg       <= time_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_time_reg   <= time_next;
            res_setup_reg  <= in_setup_next;
            res_field_reg  <= edit_field_next;
            res_hidden_reg <= hidden_next;
            res_commit_reg <= commit_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hours_out      = res_time_reg.hours;
    assign minutes_out    = res_time_reg.minutes;
    assign seconds_out    = res_time_reg.seconds;
    assign day_out        = res_time_reg.day;
    assign month_out      = res_time_reg.month;
    assign year_out       = res_time_reg.year;
    assign editing_active = res_setup_reg;
    assign chosen_field   = res_field_reg;
    assign blanked_field  = res_hidden_reg;
    assign commit         = res_commit_reg;

endmodule

[hdl/cfsc_key_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsc_key_decode
// Classifies a keypad ladder reading against the five thresholds.
// ----------------------------------------------------------------------------
module cfsc_key_decode (
    input  cfsc_pkg::limits_t              limits,
    input  logic [cfsc_pkg::LEVEL_W-1:0]   level,
    output cfsc_pkg::key_t                 key
);
    import cfsc_pkg::*;

    // first threshold that the level falls below wins
    always_comb
    begin
        priority if (level < limits.right_limit)
            key = KEY_RIGHT;
        else if (level < limits.up_limit)
            key = KEY_UP;
        else if (level < limits.down_limit)
            key = KEY_DOWN;
        else if (level < limits.left_limit)
            key = KEY_LEFT;
        else if (level < limits.select_limit)
            key = KEY_SELECT;
        else
            key = KEY_NONE;
    end

endmodule

[hdl/cfsc_field_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsc_field_step
// Steps one field of the held date and time up or down with wrap.
// ----------------------------------------------------------------------------
module cfsc_field_step (
    input  cfsc_pkg::clk_time_t  cur,
    input  logic [2:0]           field,
    input  logic                 up,
    output cfsc_pkg::clk_time_t  stepped
);
    import cfsc_pkg::*;

    logic [5:0]  hours_up;
    logic [5:0]  hours_dn;
    logic [6:0]  min_up;
    logic [6:0]  min_dn;
    logic [6:0]  sec_up;
    logic [6:0]  sec_dn;
    logic [4:0]  hours_new;
    logic [5:0]  min_new;
    logic [5:0]  sec_new;
    logic [4:0]  day_new;
    logic [3:0]  month_new;
    logic [13:0] year_new;

    // loads may go out of range; hour, minute, second wraps subtract as needed
    always_comb
    begin
        hours_up = {1'b0, cur.hours} + 6'd1;
        hours_dn = {1'b0, cur.hours} + 6'd23;
        min_up   = {1'b0, cur.minutes} + 7'd1;
        min_dn   = {1'b0, cur.minutes} + 7'd59;
        sec_up   = {1'b0, cur.seconds} + 7'd1;
        sec_dn   = {1'b0, cur.seconds} + 7'd59;

        if (up)
            hours_new = (hours_up >= 6'd24) ? 5'(hours_up - 6'd24) : hours_up[4:0];
        else if (hours_dn >= 6'd48)
            hours_new = 5'(hours_dn - 6'd48);
        else if (hours_dn >= 6'd24)
            hours_new = 5'(hours_dn - 6'd24);
        else
            hours_new = hours_dn[4:0];

        if (up)
            min_new = (min_up >= 7'd60) ? 6'(min_up - 7'd60) : min_up[5:0];
        else if (min_dn >= 7'd120)
            min_new = 6'(min_dn - 7'd120);
        else if (min_dn >= 7'd60)
            min_new = 6'(min_dn - 7'd60);
        else
            min_new = min_dn[5:0];

        if (up)
            sec_new = (sec_up >= 7'd60) ? 6'(sec_up - 7'd60) : sec_up[5:0];
        else if (sec_dn >= 7'd120)
            sec_new = 6'(sec_dn - 7'd120);
        else if (sec_dn >= 7'd60)
            sec_new = 6'(sec_dn - 7'd60);
        else
            sec_new = sec_dn[5:0];

        if (up)
            day_new = (cur.day == 5'd31) ? 5'd1 : cur.day + 5'd1;
        else
            day_new = (cur.day <= 5'd1) ? 5'd31 : cur.day - 5'd1;

        if (up)
            month_new = (cur.month >= 4'd12) ? cur.month - 4'd11 : cur.month + 4'd1;
        else
            month_new = (cur.month <= 4'd1) ? 4'd12 : cur.month - 4'd1;

        if (up)
            year_new = (cur.year >= YEAR_MAX) ? 14'd0 : cur.year + 14'd1;
        else
            year_new = (cur.year == 14'd0) ? YEAR_MAX : cur.year - 14'd1;

        stepped = cur;
        unique case (field)
            FIELD_HOURS:   stepped.hours   = hours_new;
            FIELD_MINUTES: stepped.minutes = min_new;
            FIELD_SECONDS: stepped.seconds = sec_new;
            FIELD_DAY:     stepped.day     = day_new;
            FIELD_MONTH:   stepped.month   = month_new;
            default:       stepped.year    = year_new;
        endcase
    end

endmodule
